>>> hw/rtl/fspa_pkg.sv
package fspa_pkg;

  localparam int MAX_BLOCKS     = 8;
  localparam int BLOCK_CAPACITY = 256;

  localparam int BLK_W   = $clog2(MAX_BLOCKS);
  localparam int SLOT_W  = $clog2(BLOCK_CAPACITY);
  localparam int LVL_W   = SLOT_W + 1;
  localparam int IDX_W   = BLK_W + SLOT_W;
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int ITEMS_W = $clog2(MAX_BLOCKS * BLOCK_CAPACITY + 1);
  localparam int IB_W    = 16;
  localparam int OFF_W   = 27;
  localparam int HDL_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] K_ALLOC = 2'd0;
  localparam logic [1:0] K_FREE  = 2'd1;
  localparam logic [1:0] K_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_FOREIGN  = 2'd2;
  localparam logic [1:0] ST_OVERFREE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_BYTES      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEMS_PER_BLOCK = 1'd1;

  localparam logic [IB_W-1:0] ITEM_BYTES_RST = 16'd16;

  typedef struct packed {
    logic [1:0]       kind;
    logic [HDL_W-1:0] handle;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [HDL_W-1:0]   given_handle;
    logic [OFF_W-1:0]   byte_offset;
    logic [3:0]         active_blocks;
    logic [ITEMS_W-1:0] allocated_count;
  } out_t;

endpackage

>>> hw/rtl/fspa_ram.sv
module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/fixed_size_pool_allocator.sv
// Fixed-size pool allocator with per-block free-slot stacks.
// Input channel (in_valid/in_ready, in_data): one transaction is an
// operation: allocate, free a handle, or clear all active blocks.
// Result channel (out_valid/out_ready, out_data): exactly one result per
// operation, in order: status, handle and byte offset of an allocated item,
// active block count and allocated item count after the operation.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets
// item_bytes, index 1 sets items_per_block and reinitializes the pool.
// Write it only while no operation is pending; cfg_ready is always high.
// Operation flow: an operation is accepted in S_IDLE and its result is
// registered from S_CALC once the output register is free; in_ready is low
// in S_CALC, which holds the free-slot memory read.
// If the receiver stalls, the result waits in the output register and the
// block holds the following operation until that result is taken.
// Reset: one active block with a full stack, item_bytes 16,
// items_per_block 256, no items out. Block fills and clears are lazy
// (a per-block low mark), so there is no clearing pass after reset.
module fixed_size_pool_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fspa_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fspa_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fspa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fspa_pkg::*;

  typedef enum logic {S_IDLE, S_CALC} state_t;

  state_t             state_r;
  logic [LVL_W-1:0]   level_r [MAX_BLOCKS];
  logic [LVL_W-1:0]   low_r   [MAX_BLOCKS];
  logic [CNT_W-1:0]   block_count_r;
  logic [ITEMS_W-1:0] items_out_r;
  logic [IB_W-1:0]    item_bytes_r;
  logic [LVL_W-1:0]   ipb_r;
  logic               alloc_ok_r;
  logic [1:0]         status_r;
  logic               use_fill_r;
  logic [SLOT_W-1:0]  fill_slot_r;
  logic [IDX_W-1:0]   base_r;
  logic [BLK_W-1:0]   blk_r;
  logic               out_valid_r;
  out_t               out_r;

  logic               in_fire;
  logic               out_free;
  logic [MAX_BLOCKS-1:0] avail;
  logic               any_avail;
  logic [BLK_W-1:0]   pick;
  logic               alloc_new;
  logic               alloc_ok;
  logic [BLK_W-1:0]   op_blk;
  logic [SLOT_W-1:0]  free_slot;
  logic [LVL_W-1:0]   cur_lvl;
  logic [LVL_W-1:0]   cur_low;
  logic [SLOT_W-1:0]  pos;
  logic [LVL_W-1:0]   low_nxt;
  logic               foreign;
  logic               overfree;
  logic               ram_we;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_rdata;
  logic [LVL_W-1:0]   cfg_ipb;
  logic [SLOT_W-1:0]  slot;
  logic [IDX_W-1:0]   idx;
  logic [OFF_W-1:0]   prod;
  logic [IDX_W-1:0]   base_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    for (int b = 0; b < MAX_BLOCKS; b++) begin
      avail[b] = (CNT_W'(b) < block_count_r) && (level_r[b] != '0);
    end
    any_avail = |avail;
    pick = '0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pick = BLK_W'(b);
      end
    end
  end

  assign alloc_new = !any_avail && (block_count_r < CNT_W'(MAX_BLOCKS));
  assign alloc_ok  = any_avail || alloc_new;
  assign free_slot = in_data.handle[SLOT_W-1:0];

  always_comb begin
    if (in_data.kind == K_FREE) begin
      op_blk = in_data.handle[IDX_W-1:SLOT_W];
    end else if (any_avail) begin
      op_blk = pick;
    end else begin
      op_blk = block_count_r[BLK_W-1:0];
    end
    cur_lvl = alloc_new ? ipb_r : level_r[op_blk];
    cur_low = alloc_new ? ipb_r : low_r[op_blk];
    pos     = SLOT_W'(cur_lvl - LVL_W'(1));
    low_nxt = (cur_low < {1'b0, pos}) ? cur_low : {1'b0, pos};
    base_nxt = IDX_W'(op_blk) * IDX_W'(ipb_r);
  end

  assign foreign  = ({1'b0, op_blk} >= block_count_r) || ({1'b0, free_slot} >= ipb_r);
  assign overfree = (level_r[op_blk] >= ipb_r);
  assign ram_we   = in_fire && (in_data.kind == K_FREE) && !foreign && !overfree;
  assign ram_re   = in_fire && (in_data.kind == K_ALLOC);

  always_comb begin
    cfg_ipb = cfg_data[LVL_W-1:0];
    if (cfg_ipb == '0) begin
      cfg_ipb = LVL_W'(1);
    end else if (cfg_ipb > LVL_W'(BLOCK_CAPACITY)) begin
      cfg_ipb = LVL_W'(BLOCK_CAPACITY);
    end
  end

  fspa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_BLOCKS * BLOCK_CAPACITY)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({op_blk, level_r[op_blk][SLOT_W-1:0]}),
    .wdata (free_slot),
    .re    (ram_re),
    .raddr ({op_blk, pos}),
    .rdata (ram_rdata)
  );

  assign slot = use_fill_r ? fill_slot_r : ram_rdata;
  assign idx  = base_r + IDX_W'(slot);
  assign prod = OFF_W'({{IB_W{1'b0}}, idx} * {{IDX_W{1'b0}}, item_bytes_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      block_count_r <= CNT_W'(1);
      items_out_r   <= '0;
      item_bytes_r  <= ITEM_BYTES_RST;
      ipb_r         <= LVL_W'(BLOCK_CAPACITY);
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        level_r[b] <= (b == 0) ? LVL_W'(BLOCK_CAPACITY) : '0;
        low_r[b]   <= (b == 0) ? LVL_W'(BLOCK_CAPACITY) : '0;
      end
    end else begin
      if (out_valid_r && out_ready && (state_r != S_CALC)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ITEM_BYTES) begin
          item_bytes_r <= cfg_data[IB_W-1:0];
        end else if (cfg_index == CFG_ITEMS_PER_BLOCK) begin
          ipb_r         <= cfg_ipb;
          block_count_r <= CNT_W'(1);
          items_out_r   <= '0;
          for (int b = 0; b < MAX_BLOCKS; b++) begin
            level_r[b] <= (b == 0) ? cfg_ipb : '0;
            low_r[b]   <= (b == 0) ? cfg_ipb : '0;
          end
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r    <= S_CALC;
            alloc_ok_r <= (in_data.kind == K_ALLOC) && alloc_ok;
            case (in_data.kind)
              K_ALLOC: begin
                if (alloc_ok) begin
                  status_r        <= ST_OK;
                  level_r[op_blk] <= {1'b0, pos};
                  low_r[op_blk]   <= low_nxt;
                  items_out_r     <= items_out_r + ITEMS_W'(1);
                  if (alloc_new) begin
                    block_count_r <= block_count_r + CNT_W'(1);
                  end
                end else begin
                  status_r <= ST_OOM;
                end
                use_fill_r  <= ({1'b0, pos} < cur_low);
                fill_slot_r <= SLOT_W'(ipb_r - LVL_W'(1) - {1'b0, pos});
                base_r      <= base_nxt;
                blk_r       <= op_blk;
              end
              K_FREE: begin
                if (foreign) begin
                  status_r <= ST_FOREIGN;
                end else if (overfree) begin
                  status_r <= ST_OVERFREE;
                end else begin
                  status_r        <= ST_OK;
                  level_r[op_blk] <= level_r[op_blk] + LVL_W'(1);
                  if (items_out_r != '0) begin
                    items_out_r <= items_out_r - ITEMS_W'(1);
                  end
                end
              end
              K_CLEAR: begin
                status_r <= ST_OK;
                for (int b = 0; b < MAX_BLOCKS; b++) begin
                  if (CNT_W'(b) < block_count_r) begin
                    level_r[b] <= ipb_r;
                    low_r[b]   <= ipb_r;
                  end
                end
                items_out_r <= '0;
              end
              default: begin
                status_r <= ST_OK;
              end
            endcase
          end
        end
        S_CALC: begin
          if (out_free) begin
            state_r                   <= S_IDLE;
            out_valid_r               <= 1'b1;
            out_r.status              <= status_r;
            out_r.given_handle        <= alloc_ok_r ? HDL_W'({blk_r, slot}) : '0;
            out_r.byte_offset         <= alloc_ok_r ? prod : '0;
            out_r.active_blocks       <= 4'(block_count_r);
            out_r.allocated_count     <= items_out_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("operation accepted while previous one still in progress");

  a_oom_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OOM) |->
      (out_data.active_blocks == 4'(MAX_BLOCKS)))
    else $error("out of memory reported with inactive blocks left");

  a_error_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.given_handle == '0) && (out_data.byte_offset == '0))
    else $error("failed operation returned a handle");

  a_block_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (block_count_r >= CNT_W'(1)) && (block_count_r <= CNT_W'(MAX_BLOCKS)))
    else $error("active block count out of range");

endmodule
